/* hdl/text_view_filter_defines.svh */
// assertion helpers for the checker file
`ifndef TEXT_VIEW_FILTER_DEFINES_SVH
`define TEXT_VIEW_FILTER_DEFINES_SVH

// same-cycle implication
`define TVF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvf assertion failed");

// next-cycle implication
`define TVF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvf assertion failed");

`endif

/* hdl/tvf_pkg.sv */
`timescale 1ns / 1ps

package tvf_pkg;

   localparam int CSR_INDEX_W = 3;
   // widest expansion of one character: M-^X
   localparam int CHAR_MAX    = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMBER_NONBLANK  = 3'd0,
      CSR_NUMBER_ALL       = 3'd1,
      CSR_SQUEEZE_BLANK    = 3'd2,
      CSR_SHOW_TABS        = 3'd3,
      CSR_SHOW_ENDS        = 3'd4,
      CSR_SHOW_NONPRINTING = 3'd5
   } tvf_csr_index_type;

   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squeeze_blank;
      logic show_tabs;
      logic show_ends;
      logic show_nonprinting;
   } tvf_cfg_type;

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NL        = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_DASH      = 8'h2D;
   localparam logic [7:0] CH_QMARK     = 8'h3F;
   localparam logic [7:0] CH_I         = 8'h49;
   localparam logic [7:0] CH_M         = 8'h4D;
   localparam logic [7:0] CH_CARET     = 8'h5E;
   localparam logic [7:0] CH_DEL       = 8'h7F;
   localparam logic [7:0] CH_CTRL_END  = 8'h20;
   localparam logic [7:0] CARET_OFFSET = 8'h40;
   localparam logic [3:0] ZERO_HI      = 4'h3;
   localparam logic [3:0] BCD_NINE     = 4'd9;

endpackage

/* hdl/tvf_if.sv */
`timescale 1ns / 1ps

interface tvf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       new_stream;
   modport source (output valid, in_byte, new_stream, input ready);
   modport sink   (input valid, in_byte, new_stream, output ready);
endinterface

interface tvf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

interface tvf_csr_if import tvf_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic                   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/tvf_format.sv */
`timescale 1ns / 1ps

module tvf_format import tvf_pkg::*; #(
   parameter int NUMBER_DIGITS = 6,
   parameter int MAX_RESULTS   = NUMBER_DIGITS + 1 + CHAR_MAX,
   parameter int CNT_W         = $clog2(MAX_RESULTS + 1)
) (
   input  tvf_cfg_type                          cfg,
   input  logic [7:0]                           in_byte,
   input  logic                                 new_stream,
   input  logic                                 at_start,
   input  logic                                 prev_blank,
   input  logic [4*NUMBER_DIGITS-1:0]           bcd,
   output logic [MAX_RESULTS-1:0][7:0]          res_bytes,
   output logic [CNT_W-1:0]                     res_cnt,
   output logic                                 nxt_at_start,
   output logic                                 nxt_prev_blank,
   output logic [4*NUMBER_DIGITS-1:0]           nxt_bcd
);

   localparam int BCD_W = 4 * NUMBER_DIGITS;

   logic                             eff_start;
   logic                             eff_prev;
   logic [BCD_W-1:0]                 eff_bcd;
   logic                             is_nl;
   logic                             skip;
   logic                             numbered;
   logic [CHAR_MAX-1:0][7:0]         chr;
   logic [2:0]                       ccnt;
   logic [NUMBER_DIGITS-1:0][7:0]    digit_b;
   logic [BCD_W-1:0]                 inc_bcd;
   logic [6:0]                       low;

   // new_stream takes effect before the byte
   always_comb begin
      eff_start = new_stream | at_start;
      eff_prev  = ~new_stream & prev_blank;
      eff_bcd   = new_stream ? BCD_W'(1) : bcd;
      is_nl     = (in_byte == CH_NL);
      skip      = is_nl & eff_start & cfg.squeeze_blank & eff_prev;
      if (is_nl) begin
         numbered = eff_start & ~skip & cfg.number_all & ~cfg.number_nonblank;
      end else begin
         numbered = eff_start & (cfg.number_all | cfg.number_nonblank);
      end
      if (skip) begin
         nxt_at_start   = eff_start;
         nxt_prev_blank = eff_prev;
      end else if (is_nl) begin
         nxt_at_start   = 1'b1;
         nxt_prev_blank = eff_start;
      end else begin
         nxt_at_start   = 1'b0;
         nxt_prev_blank = eff_start ? 1'b0 : eff_prev;
      end
      nxt_bcd = numbered ? inc_bcd : eff_bcd;
   end

   // saturating bcd increment
   always_comb begin
      logic carry;
      logic full;
      logic [3:0] nib;
      carry   = 1'b1;
      full    = 1'b1;
      inc_bcd = eff_bcd;
      for (int d = 0; d < NUMBER_DIGITS; d++) begin
         nib = eff_bcd[4*d +: 4];
         if (nib != BCD_NINE) full = 1'b0;
         if (carry) begin
            if (nib < BCD_NINE) begin
               inc_bcd[4*d +: 4] = nib + 4'd1;
               carry = 1'b0;
            end else begin
               inc_bcd[4*d +: 4] = 4'd0;
            end
         end
      end
      if (full) inc_bcd = eff_bcd;
   end

   // space-padded decimal, most significant digit first
   always_comb begin
      logic lead;
      logic [3:0] nib;
      lead = 1'b1;
      for (int p = 0; p < NUMBER_DIGITS; p++) begin
         nib = eff_bcd[4*(NUMBER_DIGITS-1-p) +: 4];
         if (nib == 4'd0 && lead && p < NUMBER_DIGITS - 1) begin
            digit_b[p] = CH_SPACE;
         end else begin
            lead = 1'b0;
            digit_b[p] = {ZERO_HI, (nib > BCD_NINE) ? BCD_NINE : nib};
         end
      end
   end

   // character part
   always_comb begin
      low  = in_byte[6:0];
      chr  = '0;
      ccnt = 3'd1;
      if (is_nl) begin
         if (cfg.show_ends) begin
            chr[0] = CH_DOLLAR;
            chr[1] = CH_NL;
            ccnt   = 3'd2;
         end else begin
            chr[0] = CH_NL;
         end
      end else if (in_byte == CH_TAB && cfg.show_tabs) begin
         chr[0] = CH_CARET;
         chr[1] = CH_I;
         ccnt   = 3'd2;
      end else if (!cfg.show_nonprinting) begin
         chr[0] = in_byte;
      end else if (in_byte[7]) begin
         chr[0] = CH_M;
         chr[1] = CH_DASH;
         if ({1'b0, low} < CH_CTRL_END) begin
            chr[2] = CH_CARET;
            chr[3] = {1'b0, low} + CARET_OFFSET;
            ccnt   = 3'd4;
         end else if ({1'b0, low} == CH_DEL) begin
            chr[2] = CH_CARET;
            chr[3] = CH_QMARK;
            ccnt   = 3'd4;
         end else begin
            chr[2] = {1'b0, low};
            ccnt   = 3'd3;
         end
      end else if (in_byte == CH_DEL) begin
         chr[0] = CH_CARET;
         chr[1] = CH_QMARK;
         ccnt   = 3'd2;
      end else if (in_byte < CH_CTRL_END && in_byte != CH_TAB) begin
         chr[0] = CH_CARET;
         chr[1] = in_byte + CARET_OFFSET;
         ccnt   = 3'd2;
      end else begin
         chr[0] = in_byte;
      end
   end

   always_comb begin
      if (skip) begin
         res_cnt = '0;
      end else if (numbered) begin
         res_cnt = CNT_W'(NUMBER_DIGITS + 1) + CNT_W'(ccnt);
      end else begin
         res_cnt = CNT_W'(ccnt);
      end
   end

   for (genvar i = 0; i < MAX_RESULTS; i++) begin : g_pos
      logic [7:0] num_b;
      logic [7:0] raw_b;
      if (i < NUMBER_DIGITS) begin : g_dig
         assign num_b = digit_b[i];
      end else if (i == NUMBER_DIGITS) begin : g_tab
         assign num_b = CH_TAB;
      end else begin : g_chr
         assign num_b = chr[i-NUMBER_DIGITS-1];
      end
      if (i < CHAR_MAX) begin : g_raw
         assign raw_b = chr[i];
      end else begin : g_pad
         assign raw_b = '0;
      end
      assign res_bytes[i] = numbered ? num_b : raw_b;
   end

endmodule

/* hdl/tvf_outq.sv */
`timescale 1ns / 1ps

module tvf_outq import tvf_pkg::*; #(
   parameter int MAX_RESULTS = 11,
   parameter int CNT_W       = $clog2(MAX_RESULTS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  logic [CNT_W-1:0]             push_cnt,
   input  logic [MAX_RESULTS-1:0][7:0]  push_bytes,
   output logic                         push_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_byte,
   output logic                         rsp_last
);

   // shift slot drives the output, hold slot takes the next item
   logic [CNT_W-1:0]             s_cnt_ff, s_cnt_in;
   logic [MAX_RESULTS-1:0][7:0]  s_bytes_ff, s_bytes_in;
   logic                         h_valid_ff, h_valid_in;
   logic [CNT_W-1:0]             h_cnt_ff, h_cnt_in;
   logic [MAX_RESULTS-1:0][7:0]  h_bytes_ff, h_bytes_in;
   logic                         s_fire;
   logic                         s_free;
   logic                         push_live;

   always_comb begin
      s_fire     = (s_cnt_ff != '0) && rsp_ready;
      s_free     = (s_cnt_ff == '0) || (s_cnt_ff == CNT_W'(1) && rsp_ready);
      push_ready = !h_valid_ff || s_free;
      push_live  = push_valid && (push_cnt != '0);

      s_cnt_in   = s_cnt_ff;
      s_bytes_in = s_bytes_ff;
      h_valid_in = h_valid_ff;
      h_cnt_in   = h_cnt_ff;
      h_bytes_in = h_bytes_ff;

      if (s_fire) begin
         s_cnt_in   = s_cnt_ff - CNT_W'(1);
         s_bytes_in = {8'h00, s_bytes_ff[MAX_RESULTS-1:1]};
      end
      if (s_free) begin
         if (h_valid_ff) begin
            s_cnt_in   = h_cnt_ff;
            s_bytes_in = h_bytes_ff;
            h_valid_in = push_live;
            h_cnt_in   = push_cnt;
            h_bytes_in = push_bytes;
         end else if (push_live) begin
            s_cnt_in   = push_cnt;
            s_bytes_in = push_bytes;
         end
      end else if (push_live) begin
         h_valid_in = 1'b1;
         h_cnt_in   = push_cnt;
         h_bytes_in = push_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_cnt_ff   <= '0;
         h_valid_ff <= 1'b0;
      end else begin
         s_cnt_ff   <= s_cnt_in;
         h_valid_ff <= h_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_bytes_ff <= s_bytes_in;
      h_cnt_ff   <= h_cnt_in;
      h_bytes_ff <= h_bytes_in;
   end

   assign rsp_valid = (s_cnt_ff != '0);
   assign rsp_byte  = s_bytes_ff[0];
   assign rsp_last  = (s_cnt_ff == CNT_W'(1));

endmodule

/* hdl/text_view_filter.sv */
`timescale 1ns / 1ps

// cat-style text viewer on a byte stream
// req_port: one raw text byte per transfer, new_stream restarts line number
//    and line state before that byte
// rsp_port: the formatted bytes, one per transfer, last set on the final
//    byte that an input byte produces; a squeezed blank line produces none
// csr_port: one option bit per register index, always ready; write it only
//    while no item is in flight
// output: each expansion is registered into the output queue before its first byte is sent
// throughput: an input byte produces 0 to NUMBER_DIGITS+5 output bytes, sent
//    one per transfer; a byte with one output byte sustains one transfer per
//    cycle while rsp_port.ready holds, set by the one-byte-wide output shifter
// a two-entry output queue (shift slot plus hold slot) lets the next byte
//    be taken while the current expansion is still being sent
// reset: options clear, line number returns to 1, at line start, queue empty
// receiver stall: the output byte holds, and once the hold slot is full
//    req_port.ready drops until the shift slot drains
module text_view_filter import tvf_pkg::*; #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic     clock,
   input  logic     reset,
   tvf_req_if.sink  req_port,
   tvf_rsp_if.source rsp_port,
   tvf_csr_if.sink  csr_port
);

   localparam int MAX_RESULTS = NUMBER_DIGITS + 1 + CHAR_MAX;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int BCD_W       = 4 * NUMBER_DIGITS;

   // option registers
   tvf_cfg_type cfg_ff, cfg_in;

   // line state
   logic              at_start_ff, at_start_in;
   logic              prev_blank_ff, prev_blank_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;

   // expansion of the current input byte
   logic [MAX_RESULTS-1:0][7:0] fmt_bytes;
   logic [CNT_W-1:0]            fmt_cnt;
   logic                        req_fire;

   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         case (tvf_csr_index_type'(csr_port.index))
            CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_port.data;
            CSR_NUMBER_ALL:       cfg_in.number_all       = csr_port.data;
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_port.data;
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_port.data;
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_port.data;
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_port.data;
            default:              cfg_in = cfg_ff;   // unused indexes are ignored
         endcase
      end
   end

   tvf_format #(
      .NUMBER_DIGITS (NUMBER_DIGITS),
      .MAX_RESULTS   (MAX_RESULTS),
      .CNT_W         (CNT_W)
   ) u_format (
      .cfg            (cfg_ff),
      .in_byte        (req_port.in_byte),
      .new_stream     (req_port.new_stream),
      .at_start       (at_start_ff),
      .prev_blank     (prev_blank_ff),
      .bcd            (bcd_ff),
      .res_bytes      (fmt_bytes),
      .res_cnt        (fmt_cnt),
      .nxt_at_start   (at_start_in),
      .nxt_prev_blank (prev_blank_in),
      .nxt_bcd        (bcd_in)
   );

   // line state advances on every input transfer, even one with no output
   assign req_fire = req_port.valid && req_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         at_start_ff   <= 1'b1;
         prev_blank_ff <= 1'b0;
         bcd_ff        <= BCD_W'(1);
      end else begin
         cfg_ff <= cfg_in;
         if (req_fire) begin
            at_start_ff   <= at_start_in;
            prev_blank_ff <= prev_blank_in;
            bcd_ff        <= bcd_in;
         end
      end
   end

   tvf_outq #(
      .MAX_RESULTS (MAX_RESULTS),
      .CNT_W       (CNT_W)
   ) u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_fire),
      .push_cnt   (fmt_cnt),
      .push_bytes (fmt_bytes),
      .push_ready (req_port.ready),
      .rsp_valid  (rsp_port.valid),
      .rsp_ready  (rsp_port.ready),
      .rsp_byte   (rsp_port.out_byte),
      .rsp_last   (rsp_port.last)
   );

endmodule

/* hdl/tvf_checker.sv */
`timescale 1ns / 1ps
`include "text_view_filter_defines.svh"

module tvf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // nothing left over from before reset
   `TVF_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // a stalled output byte holds
   `TVF_ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))

   // the bytes of one expansion follow without a gap
   `TVF_ASSERT_NXT(a_no_gap, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)

   // an empty output side never blocks the input
   `TVF_ASSERT_IMP(a_idle_ready, clock, reset, !rsp_valid, req_ready)

endmodule

bind text_view_filter tvf_checker u_tvf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_port.ready),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .rsp_out_byte (rsp_port.out_byte),
   .rsp_last     (rsp_port.last)
);

/* tb/text_view_filter_test.sv */
`timescale 1ns / 1ps

module text_view_filter_test;
   import tvf_pkg::*;

   localparam int DIGITS     = 6;
   localparam int STALL_MAX  = 2000;   // cycles with no transfer on any channel
   localparam int SETTLE     = 4;      // cycles past the last result before idle
   localparam int PRINT_MAX  = 40;
   localparam int COUNT_RUN  = 25;     // blank lines for the counter walk
   localparam int RAND_RUN   = 24;     // random bytes per option setting

   typedef struct packed {
      logic [7:0] ch;
      logic       restart;
   } text_byte_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } view_byte_type;

   logic clock;
   logic reset;

   tvf_req_if req_port ();
   tvf_rsp_if rsp_port ();
   tvf_csr_if csr_port ();

   text_view_filter #(.NUMBER_DIGITS(DIGITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port),
      .csr_port (csr_port)
   );

   // bytes waiting to be sent and formatted bytes still owed by the block
   text_byte_type text_pending[$];
   view_byte_type view_due[$];

   // shadow of the option registers and the line state
   tvf_cfg_type           opts;
   logic [4*DIGITS-1:0]   line_bcd;
   logic                  at_start;
   logic                  prev_blank;

   bit req_taken;
   bit steady;          // when set neither side idles
   int errors;
   int bytes_sent;
   int bytes_checked;
   int settings_used;
   int quiet_cycles;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (errors < PRINT_MAX)
         $display("%0t mismatch: %s", $realtime, what);
      errors++;
   endtask

   function automatic bit take_gap();
      return !steady && ($urandom_range(99) < 26);
   endfunction

   // ---------------------------------------------------------------
   // formatting predictor
   // ---------------------------------------------------------------

   function automatic void put_view(input logic [7:0] b);
      view_byte_type v;
      v.data = b;
      v.last = 1'b0;
      view_due.push_back(v);
   endfunction

   // space-padded decimal line number followed by a tab
   function automatic void put_line_number();
      bit         leading;
      logic [3:0] nib;
      int         d;
      leading = 1'b1;
      for (d = DIGITS - 1; d >= 0; d--) begin
         nib = line_bcd[4*d +: 4];
         if (nib == 4'd0 && leading && d > 0) begin
            put_view(CH_SPACE);
         end else begin
            leading = 1'b0;
            put_view({ZERO_HI, (nib > BCD_NINE) ? BCD_NINE : nib});
         end
      end
      put_view(CH_TAB);
   endfunction

   // decimal increment that sticks at all nines
   function automatic void bump_line_number();
      logic [4*DIGITS-1:0] v;
      bit                  full;
      bit                  done;
      int                  d;
      full = 1'b1;
      for (d = 0; d < DIGITS; d++)
         if (line_bcd[4*d +: 4] != BCD_NINE)
            full = 1'b0;
      if (full)
         return;
      v    = line_bcd;
      done = 1'b0;
      for (d = 0; d < DIGITS && !done; d++) begin
         if (v[4*d +: 4] < BCD_NINE) begin
            v[4*d +: 4] = v[4*d +: 4] + 4'd1;
            done = 1'b1;
         end else begin
            v[4*d +: 4] = 4'd0;
         end
      end
      line_bcd = v;
   endfunction

   // one text character in tab, caret and meta notation
   function automatic void put_shown_char(input logic [7:0] ch);
      logic [7:0] low;
      if (ch == CH_TAB && opts.show_tabs) begin
         put_view(CH_CARET);
         put_view(CH_I);
         return;
      end
      if (!opts.show_nonprinting) begin
         put_view(ch);
         return;
      end
      if (ch[7]) begin
         low = {1'b0, ch[6:0]};
         put_view(CH_M);
         put_view(CH_DASH);
         if (low < CH_CTRL_END) begin
            put_view(CH_CARET);
            put_view(low + CARET_OFFSET);
         end else if (low == CH_DEL) begin
            put_view(CH_CARET);
            put_view(CH_QMARK);
         end else begin
            put_view(low);
         end
         return;
      end
      if (ch == CH_DEL) begin
         put_view(CH_CARET);
         put_view(CH_QMARK);
      end else if (ch < CH_CTRL_END && ch != CH_TAB) begin
         put_view(CH_CARET);
         put_view(ch + CARET_OFFSET);
      end else begin
         put_view(ch);
      end
   endfunction

   // everything the viewer prints for one input byte
   function automatic void format_text_byte(input logic [7:0] ch, input logic restart);
      view_byte_type tail;
      int            first;
      first = view_due.size();
      if (restart) begin
         line_bcd   = (4*DIGITS)'(1);
         at_start   = 1'b1;
         prev_blank = 1'b0;
      end
      if (ch == CH_NL) begin
         if (at_start) begin
            // blank line after a blank line disappears when squeezing
            if (opts.squeeze_blank && prev_blank)
               return;
            if (opts.number_all && !opts.number_nonblank) begin
               put_line_number();
               bump_line_number();
            end
            prev_blank = 1'b1;
         end else begin
            prev_blank = 1'b0;
         end
         if (opts.show_ends)
            put_view(CH_DOLLAR);
         put_view(CH_NL);
         at_start = 1'b1;
      end else begin
         if (at_start) begin
            if (opts.number_nonblank || opts.number_all) begin
               put_line_number();
               bump_line_number();
            end
            at_start   = 1'b0;
            prev_blank = 1'b0;
         end
         put_shown_char(ch);
      end
      if (view_due.size() > first) begin
         tail      = view_due.pop_back();
         tail.last = 1'b1;
         view_due.push_back(tail);
      end
   endfunction

   function automatic void write_option(input logic [CSR_INDEX_W-1:0] idx, input logic bit0);
      case (tvf_csr_index_type'(idx))
         CSR_NUMBER_NONBLANK:  opts.number_nonblank  = bit0;
         CSR_NUMBER_ALL:       opts.number_all       = bit0;
         CSR_SQUEEZE_BLANK:    opts.squeeze_blank    = bit0;
         CSR_SHOW_TABS:        opts.show_tabs        = bit0;
         CSR_SHOW_ENDS:        opts.show_ends        = bit0;
         CSR_SHOW_NONPRINTING: opts.show_nonprinting = bit0;
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // driver: input side at the falling edge, plus output back-pressure
   // ---------------------------------------------------------------

   always @(negedge clock) begin : driver
      text_byte_type nxt;
      if (reset) begin
         req_port.valid <= 1'b0;
      end else if (!req_port.valid || req_taken) begin
         // previous transfer done (or nothing held): maybe present the next byte
         if (text_pending.size() != 0 && !take_gap()) begin
            nxt = text_pending.pop_front();
            req_port.valid      <= 1'b1;
            req_port.in_byte    <= nxt.ch;
            req_port.new_stream <= nxt.restart;
         end else begin
            req_port.valid <= 1'b0;
         end
      end
      rsp_port.ready <= !take_gap();
   end

   // ---------------------------------------------------------------
   // monitor: every channel sampled at the rising edge
   // ---------------------------------------------------------------

   always @(posedge clock) begin : monitor
      view_byte_type want;
      req_taken = req_port.valid && req_port.ready;
      if (reset) begin
         opts       = '0;
         line_bcd   = (4*DIGITS)'(1);
         at_start   = 1'b1;
         prev_blank = 1'b0;
         view_due.delete();
      end else begin
         if (csr_port.valid && csr_port.ready)
            write_option(csr_port.index, csr_port.data);
         // check the output first so a same-edge input cannot hide a stray byte
         if (rsp_port.valid && rsp_port.ready) begin
            bytes_checked++;
            if (view_due.size() == 0) begin
               report_mismatch($sformatf("output byte %02h with nothing owed",
                                         rsp_port.out_byte));
            end else begin
               want = view_due.pop_front();
               if (rsp_port.out_byte !== want.data)
                  report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                            rsp_port.out_byte, want.data));
               if (rsp_port.last !== want.last)
                  report_mismatch($sformatf("last %b, wanted %b (byte %02h)",
                                            rsp_port.last, want.last, want.data));
            end
         end
         if (req_taken) begin
            bytes_sent++;
            format_text_byte(req_port.in_byte, req_port.new_stream);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_port.valid && req_port.ready) || (rsp_port.valid && rsp_port.ready)
          || (csr_port.valid && csr_port.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("text_view_filter_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   task automatic queue_byte(input logic [7:0] ch, input logic restart = 1'b0);
      text_byte_type t;
      t.ch      = ch;
      t.restart = restart;
      text_pending.push_back(t);
   endtask

   // text-like bytes: short lines, some tabs, controls and meta bytes
   task automatic queue_random_text(input int n);
      int         i;
      int         pick;
      logic [7:0] ch;
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 16)
            ch = CH_NL;
         else if (pick < 22)
            ch = CH_TAB;
         else if (pick < 32)
            ch = 8'($urandom_range(255));
         else if (pick < 38)
            ch = 8'($urandom_range(255, 128));
         else if (pick < 42)
            ch = 8'($urandom_range(31));
         else
            ch = 8'($urandom_range(126, 32));
         queue_byte(ch, $urandom_range(99) < 4);
      end
   endtask

   // wait until the sender is empty and every owed byte has arrived
   task automatic wait_idle();
      do
         @(posedge clock);
      while (text_pending.size() != 0 || req_port.valid || view_due.size() != 0);
      // a squeezed line may still be in flight with nothing owed
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_options(input tvf_cfg_type c);
      tvf_csr_index_type idx[6];
      logic              val[6];
      int                i;
      idx = '{CSR_NUMBER_NONBLANK, CSR_NUMBER_ALL, CSR_SQUEEZE_BLANK,
              CSR_SHOW_TABS, CSR_SHOW_ENDS, CSR_SHOW_NONPRINTING};
      val = '{c.number_nonblank, c.number_all, c.squeeze_blank,
              c.show_tabs, c.show_ends, c.show_nonprinting};
      for (i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_port.valid <= 1'b1;
         csr_port.index <= idx[i];
         csr_port.data  <= val[i];
         do
            @(posedge clock);
         while (!csr_port.ready);
      end
      @(negedge clock);
      csr_port.valid <= 1'b0;
      settings_used++;
   endtask

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------

   initial begin : stimulus
      tvf_cfg_type c;
      int          phase;
      int          i;

      clock               = 1'b0;
      reset               = 1'b1;
      req_port.valid      = 1'b0;
      req_port.in_byte    = '0;
      req_port.new_stream = 1'b0;
      rsp_port.ready      = 1'b0;
      csr_port.valid      = 1'b0;
      csr_port.index      = '0;
      csr_port.data       = 1'b0;
      steady              = 1'b0;
      errors              = 0;
      bytes_sent          = 0;
      bytes_checked       = 0;
      settings_used       = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // options at reset: everything passes raw, including 0xff
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(CH_TAB);
      queue_byte(CH_NL);
      queue_byte(CH_NL);
      queue_byte(8'h78);
      wait_idle();

      // every option on; non-blank numbering wins over number-all
      set_options('1);
      queue_byte(8'h41, 1'b1);
      queue_byte(8'h00);
      queue_byte(CH_TAB);
      queue_byte(8'h1F);
      queue_byte(CH_DEL);
      queue_byte(8'h80);
      queue_byte(8'h89);          // meta tab
      queue_byte(8'h8A);          // meta newline
      queue_byte(8'hA0);
      queue_byte(8'hFF);
      queue_byte(CH_NL);
      queue_byte(CH_NL);
      queue_byte(CH_NL);          // squeezed away
      queue_byte(CH_NL);          // squeezed away
      queue_byte(8'h62);
      queue_byte(CH_NL);
      wait_idle();

      // number every line; a tab stays raw without show_tabs
      c                  = '0;
      c.number_all       = 1'b1;
      c.show_nonprinting = 1'b1;
      set_options(c);
      queue_byte(CH_TAB);
      queue_byte(CH_NL);
      queue_byte(CH_NL);
      wait_idle();

      // random text under a spread of option settings, extremes first
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       c = '0;
            1:       c = '1;
            default: c = tvf_cfg_type'(6'($urandom_range(63)));
         endcase
         set_options(c);
         steady = (phase == 3);
         if (phase == 5) begin
            // sender holds off until the block has drained completely
            queue_random_text(RAND_RUN / 2);
            wait_idle();
            queue_random_text(RAND_RUN / 2);
         end else begin
            queue_random_text(RAND_RUN);
         end
         wait_idle();
      end

      // walk the line counter through a couple of decimal carries
      c            = '0;
      c.number_all = 1'b1;
      set_options(c);
      steady = 1'b1;
      queue_byte(CH_NL, 1'b1);
      for (i = 1; i < COUNT_RUN; i++)
         queue_byte(CH_NL);
      wait_idle();
      steady = 1'b0;

      repeat (10) @(posedge clock);
      if (view_due.size() != 0)
         report_mismatch($sformatf("%0d output bytes never arrived", view_due.size()));

      $display("sent %0d text bytes under %0d option settings, checked %0d output bytes",
               bytes_sent, settings_used, bytes_checked);
      $display("numbered %0d blank lines in a row to step the line counter", COUNT_RUN);
      if (errors == 0) begin
         $display("text_view_filter_test OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("text_view_filter_test NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/tvf_pkg.sv
hdl/tvf_if.sv
hdl/tvf_format.sv
hdl/tvf_outq.sv
hdl/text_view_filter.sv
hdl/tvf_checker.sv
tb/text_view_filter_test.sv
